[sv/rrss_pkg.sv]
// ----------------------------------------------------------------------------
// rrss_pkg: shared types and constants of the round-robin slice scheduler
// Field widths, status and mode codes, register indexes, reset values and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rrss_pkg;

  localparam int unsigned MAX_TASKS_DEF = 64;

  localparam int unsigned BURST_W   = 16;
  localparam int unsigned RAM_W     = 12;
  localparam int unsigned CPU_W     = 8;
  localparam int unsigned PRIO_W    = 2;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned TIDX_W    = 6;
  localparam int unsigned ELAPSED_W = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [BURST_W-1:0] QUANTUM_RST   = 16'd8;
  localparam logic [RAM_W-1:0]   POOL_TOP_RST  = 12'd512;
  localparam logic [RAM_W-1:0]   POOL_OTH_RST  = 12'd1536;
  localparam logic [CPU_W-1:0]   CPU_CAP_RST   = 8'd100;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_STEP  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED    = 3'd0,
    ST_REQUEUED  = 3'd1,
    ST_COMPLETED = 3'd2,
    ST_REJECTED  = 3'd3,
    ST_ALL_DONE  = 3'd4,
    ST_FULL      = 3'd5,
    ST_CLEARED   = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUANTUM  = 2'd0,
    CFG_POOL_TOP = 2'd1,
    CFG_POOL_OTH = 2'd2,
    CFG_CPU_CAP  = 2'd3
  } cfg_idx_e;

  // One task table entry
  typedef struct packed {
    logic [BURST_W-1:0] rem;
    logic [RAM_W-1:0]   ram;
    logic [CPU_W-1:0]   cpu;
    logic               top;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic do_load;
    logic do_clear;
    logic do_search;
    logic do_read;
    logic do_exec;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

[sv/rrss_ctrl.sv]
// ----------------------------------------------------------------------------
// rrss_ctrl: scheduler controller
// Sequences one request at a time: load, clear, or a step made of search,
// table read and execute. Result states wait for a free output register.
// ----------------------------------------------------------------------------
module rrss_ctrl
  import rrss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [MODE_W-1:0] in_mode_i,
  output logic              in_ready_o,
  input  sts_t              sts_i,
  output cmd_t              cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOAD   = 6'b000010,
    S_CLEAR  = 6'b000100,
    S_SEARCH = 6'b001000,
    S_READ   = 6'b010000,
    S_EXEC   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (mode_e'(in_mode_i))
            MODE_LOAD:  state_d = S_LOAD;
            MODE_STEP:  state_d = S_SEARCH;
            MODE_CLEAR: state_d = S_CLEAR;
            default:    state_d = S_IDLE; // drop unused mode
          endcase
        end
      end
      S_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.do_load = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (sts_i.out_free) begin
          cmd_o.do_clear = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_SEARCH: begin
        cmd_o.do_search = 1'b1;
        state_d         = S_READ;
      end
      S_READ: begin
        cmd_o.do_read = 1'b1;
        state_d       = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.do_exec = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/rrss_dp.sv]
// ----------------------------------------------------------------------------
// rrss_dp: scheduler datapath
// Task table memory, live bits, next-task search, resource check, slice
// arithmetic, counters and the output register.
// ----------------------------------------------------------------------------
module rrss_dp
  import rrss_pkg::*;
#(
  parameter int unsigned MaxTasks = MAX_TASKS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [BURST_W-1:0]   in_burst_time_i,
  input  logic [RAM_W-1:0]     in_task_ram_i,
  input  logic [CPU_W-1:0]     in_task_cpu_i,
  input  logic [PRIO_W-1:0]    in_task_priority_i,
  input  logic [BURST_W-1:0]   quantum_i,
  input  logic [RAM_W-1:0]     pool_top_i,
  input  logic [RAM_W-1:0]     pool_oth_i,
  input  logic [CPU_W-1:0]     cpu_cap_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [STATUS_W-1:0]  out_status_o,
  output logic [TIDX_W-1:0]    out_task_index_o,
  output logic [BURST_W-1:0]   out_run_length_o,
  output logic [ELAPSED_W-1:0] out_elapsed_time_o
);

  localparam int unsigned IdxW = $clog2(MaxTasks);
  localparam int unsigned CntW = $clog2(MaxTasks + 1);
  localparam int unsigned VecW = 2 * MaxTasks;

  function automatic logic [IdxW-1:0] encode(input logic [MaxTasks-1:0] oh);
    logic [IdxW-1:0] r;
    r = '0;
    for (int i = 0; i < MaxTasks; i++) begin
      if (oh[i]) r = r | IdxW'(i);
    end
    return r;
  endfunction

  function automatic logic [TIDX_W-1:0] low_index(input logic [IdxW-1:0] v);
    logic [IdxW+TIDX_W-1:0] t;
    t = {{TIDX_W{1'b0}}, v};
    return t[TIDX_W-1:0];
  endfunction

  // captured request
  logic [BURST_W-1:0] burst_q;
  logic [RAM_W-1:0]   ram_q;
  logic [CPU_W-1:0]   cpu_q;
  logic               top_q;

  logic [CntW-1:0]      task_count_q, next_slot_q;
  logic [ELAPSED_W-1:0] acc_q;
  logic [MaxTasks-1:0]  live_q;
  logic [MaxTasks-1:0]  oh_q, oh_d, ge_mask;
  logic                 found_q;
  logic [IdxW-1:0]      idx_q, idx_d;
  entry_t               rd_q;
  entry_t               mem [MaxTasks];

  logic [VecW-1:0] vec, iso;
  logic            full;
  logic [IdxW-1:0] load_idx;

  logic [BURST_W-1:0] q_eff, run, new_rem;
  logic [RAM_W-1:0]   pool;
  logic               res_ok;

  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  entry_t          mem_wdata;

  logic                 out_valid_q;
  status_e              out_status_q;
  logic [TIDX_W-1:0]    out_tidx_q;
  logic [BURST_W-1:0]   out_run_q;
  logic [ELAPSED_W-1:0] out_elapsed_q;

  assign full     = (task_count_q == CntW'(MaxTasks));
  assign load_idx = task_count_q[IdxW-1:0];

  // First live slot at or after next_slot, wrapping to the lowest live slot.
  // Live bits exist only below task_count, so a stale next_slot just wraps.
  always_comb begin
    for (int i = 0; i < MaxTasks; i++) begin
      ge_mask[i] = (CntW'(i) >= next_slot_q);
    end
    vec = {live_q, live_q & ge_mask};
    iso = vec & (~vec + VecW'(1));
    for (int i = 0; i < MaxTasks; i++) begin
      oh_d[i] = iso[i] | iso[i + MaxTasks];
    end
  end

  assign idx_d = encode(oh_q);

  // slice arithmetic on the entry read back
  always_comb begin
    q_eff   = (quantum_i == '0) ? BURST_W'(1) : quantum_i;
    run     = (rd_q.rem < q_eff) ? rd_q.rem : q_eff;
    new_rem = rd_q.rem - run;
    pool    = rd_q.top ? pool_top_i : pool_oth_i;
    res_ok  = (rd_q.ram <= pool) && (rd_q.cpu <= cpu_cap_i);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = rd_q;
    if (cmd_i.do_load) begin
      mem_we    = !full;
      mem_waddr = load_idx;
      mem_wdata = '{rem: burst_q, ram: ram_q, cpu: cpu_q, top: top_q};
    end else if (cmd_i.do_exec) begin
      mem_we        = found_q && res_ok;
      mem_wdata.rem = new_rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.do_read) rd_q <= mem[idx_d];
  end

  // request capture and search pipeline registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      burst_q <= in_burst_time_i;
      ram_q   <= in_task_ram_i;
      cpu_q   <= in_task_cpu_i;
      top_q   <= (in_task_priority_i == '0);
    end
    if (cmd_i.do_search) begin
      oh_q    <= oh_d;
      found_q <= |live_q;
    end
    if (cmd_i.do_read) idx_q <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= '0;
      next_slot_q  <= '0;
      acc_q        <= '0;
      live_q       <= '0;
    end else if (cmd_i.do_clear) begin
      task_count_q <= '0;
      next_slot_q  <= '0;
      acc_q        <= '0;
      live_q       <= '0;
    end else if (cmd_i.do_load && !full) begin
      task_count_q     <= task_count_q + CntW'(1);
      live_q[load_idx] <= (burst_q != '0);
    end else if (cmd_i.do_exec && found_q) begin
      next_slot_q   <= CntW'(idx_q) + CntW'(1);
      live_q[idx_q] <= res_ok && (new_rem != '0);
      if (res_ok) acc_q <= acc_q + ELAPSED_W'(run);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.do_load || cmd_i.do_clear || cmd_i.do_exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_load) begin
      out_status_q  <= full ? ST_FULL : ST_LOADED;
      out_tidx_q    <= full ? '0 : low_index(load_idx);
      out_run_q     <= '0;
      out_elapsed_q <= acc_q;
    end else if (cmd_i.do_clear) begin
      out_status_q  <= ST_CLEARED;
      out_tidx_q    <= '0;
      out_run_q     <= '0;
      out_elapsed_q <= '0;
    end else if (cmd_i.do_exec) begin
      if (!found_q) begin
        out_status_q  <= ST_ALL_DONE;
        out_tidx_q    <= '0;
        out_run_q     <= '0;
        out_elapsed_q <= acc_q;
      end else if (!res_ok) begin
        out_status_q  <= ST_REJECTED;
        out_tidx_q    <= low_index(idx_q);
        out_run_q     <= '0;
        out_elapsed_q <= acc_q;
      end else begin
        out_status_q  <= (new_rem == '0) ? ST_COMPLETED : ST_REQUEUED;
        out_tidx_q    <= low_index(idx_q);
        out_run_q     <= run;
        out_elapsed_q <= acc_q + ELAPSED_W'(run);
      end
    end
  end

  assign sts_o.out_free     = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_status_o       = out_status_q;
  assign out_task_index_o   = out_tidx_q;
  assign out_run_length_o   = out_run_q;
  assign out_elapsed_time_o = out_elapsed_q;

endmodule

[sv/round_robin_slice_scheduler_top.sv]
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler_top: round-robin time-slice task scheduler
// Loads tasks into a table, serves the next live task per step request with
// a RAM/CPU check, and reports slot, run length and elapsed time.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   in      | sink      | in_valid_i/in_ready_o | mode, burst, ram, cpu, prio
//   out     | source    | out_valid_o/ready_i   | status, index, run, elapsed
//   cfg     | sink      | cfg_valid_i/ready_o   | cfg_index_i, cfg_data_i
//
// One request is in flight at a time. Load and clear each have their own
// state; a step goes through live-slot search, a registered read of the
// task table and execute. A result waits in the output register while
// out_ready_i is low; the request after it is taken meanwhile and stalls
// only at its own result. Reset empties the table at once (live bits), no
// clearing pass. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler_top
  import rrss_pkg::*;
#(
  parameter int unsigned MaxTasks = MAX_TASKS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [MODE_W-1:0]    in_mode_i,
  input  logic [BURST_W-1:0]   in_burst_time_i,
  input  logic [RAM_W-1:0]     in_task_ram_i,
  input  logic [CPU_W-1:0]     in_task_cpu_i,
  input  logic [PRIO_W-1:0]    in_task_priority_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [STATUS_W-1:0]  out_status_o,
  output logic [TIDX_W-1:0]    out_task_index_o,
  output logic [BURST_W-1:0]   out_run_length_o,
  output logic [ELAPSED_W-1:0] out_elapsed_time_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  logic [BURST_W-1:0] quantum_q;
  logic [RAM_W-1:0]   pool_top_q, pool_oth_q;
  logic [CPU_W-1:0]   cpu_cap_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q  <= QUANTUM_RST;
      pool_top_q <= POOL_TOP_RST;
      pool_oth_q <= POOL_OTH_RST;
      cpu_cap_q  <= CPU_CAP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_QUANTUM:  quantum_q  <= cfg_data_i[BURST_W-1:0];
        CFG_POOL_TOP: pool_top_q <= cfg_data_i[RAM_W-1:0];
        CFG_POOL_OTH: pool_oth_q <= cfg_data_i[RAM_W-1:0];
        CFG_CPU_CAP:  cpu_cap_q  <= cfg_data_i[CPU_W-1:0];
        default: ;
      endcase
    end
  end

  rrss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_mode_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrss_dp #(
    .MaxTasks (MaxTasks)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .in_burst_time_i    (in_burst_time_i),
    .in_task_ram_i      (in_task_ram_i),
    .in_task_cpu_i      (in_task_cpu_i),
    .in_task_priority_i (in_task_priority_i),
    .quantum_i          (quantum_q),
    .pool_top_i         (pool_top_q),
    .pool_oth_i         (pool_oth_q),
    .cpu_cap_i          (cpu_cap_q),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .out_status_o       (out_status_o),
    .out_task_index_o   (out_task_index_o),
    .out_run_length_o   (out_run_length_o),
    .out_elapsed_time_o (out_elapsed_time_o)
  );

  // a result appears only right after a result-producing command
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.do_load || cmd.do_clear || cmd.do_exec))
    else $error("result without a producing command");

  // an accepted step request starts the search on the next cycle
  a_step_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_mode_i == MODE_STEP) |=> cmd.do_search)
    else $error("step request did not start a search");

  // a cleared table reports zero elapsed time
  a_clear_elapsed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o == ST_CLEARED) |-> (out_elapsed_time_o == '0))
    else $error("clear result with nonzero elapsed time");

endmodule

[verif/round_robin_slice_scheduler_top_test.sv]
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler_top_test: self-checking bench of the scheduler
// Drives load, step and clear requests through the valid/ready port with
// random gaps and output stalls. An internal task-table model predicts every
// report and each report is compared field by field in order. The quantum,
// RAM pool and CPU capacity registers are reprogrammed between idle phases.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler_top_test;
  import rrss_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 12;
  localparam int TARGET_REQUESTS = 1750;
  localparam int DIR_ROWS = 19;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [BURST_W-1:0] burst;
    logic [RAM_W-1:0]   ram;
    logic [CPU_W-1:0]   cpu;
    logic [PRIO_W-1:0]  prio;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [TIDX_W-1:0]    idx;
    logic [BURST_W-1:0]   run;
    logic [ELAPSED_W-1:0] elapsed;
  } report_t;

  typedef struct packed {
    req_t    req;
    logic    fixed;
    report_t rep;
  } dir_row_t;

  localparam report_t NO_REP = '{ST_LOADED, 6'd0, 16'd0, 32'd0};

  // Fixed rows carry a report that is obvious by inspection
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{'{MODE_STEP,  16'd0,     12'd0,     8'd0,   2'd0}, 1'b1, '{ST_ALL_DONE, 6'd0, 16'd0, 32'd0}},
    '{'{MODE_CLEAR, 16'd0,     12'd0,     8'd0,   2'd0}, 1'b1, '{ST_CLEARED,  6'd0, 16'd0, 32'd0}},
    '{'{MODE_LOAD,  16'hffff,  12'hfff,   8'hff,  2'd3}, 1'b1, '{ST_LOADED,   6'd0, 16'd0, 32'd0}},
    '{'{MODE_LOAD,  16'd0,     12'd0,     8'd0,   2'd0}, 1'b1, '{ST_LOADED,   6'd1, 16'd0, 32'd0}},
    '{'{MODE_LOAD,  16'd20,    12'd512,   8'd100, 2'd0}, 1'b1, '{ST_LOADED,   6'd2, 16'd0, 32'd0}},
    '{'{MODE_LOAD,  16'd3,     12'd513,   8'd0,   2'd0}, 1'b1, '{ST_LOADED,   6'd3, 16'd0, 32'd0}},
    '{'{MODE_LOAD,  16'd5,     12'd1536,  8'd101, 2'd2}, 1'b1, '{ST_LOADED,   6'd4, 16'd0, 32'd0}},
    '{'{MODE_LOAD,  16'd1,     12'd1536,  8'd100, 2'd1}, 1'b1, '{ST_LOADED,   6'd5, 16'd0, 32'd0}},
    '{'{MODE_STEP,  16'd0,     12'd0,     8'd0,   2'd0}, 1'b1, '{ST_REJECTED, 6'd0, 16'd0, 32'd0}},
    '{'{MODE_STEP,  16'd0,     12'd0,     8'd0,   2'd0}, 1'b0, NO_REP},
    '{'{MODE_STEP,  16'd0,     12'd0,     8'd0,   2'd0}, 1'b0, NO_REP},
    '{'{MODE_STEP,  16'd0,     12'd0,     8'd0,   2'd0}, 1'b0, NO_REP},
    '{'{MODE_STEP,  16'd0,     12'd0,     8'd0,   2'd0}, 1'b0, NO_REP},
    '{'{MODE_STEP,  16'd0,     12'd0,     8'd0,   2'd0}, 1'b0, NO_REP},
    '{'{MODE_STEP,  16'd0,     12'd0,     8'd0,   2'd0}, 1'b0, NO_REP},
    '{'{MODE_STEP,  16'd0,     12'd0,     8'd0,   2'd0}, 1'b0, NO_REP},
    '{'{MODE_UNUSED, 16'hffff, 12'hfff,   8'hff,  2'd3}, 1'b0, NO_REP},
    '{'{MODE_CLEAR, 16'd0,     12'd0,     8'd0,   2'd0}, 1'b1, '{ST_CLEARED,  6'd0, 16'd0, 32'd0}},
    '{'{MODE_STEP,  16'd0,     12'd0,     8'd0,   2'd0}, 1'b1, '{ST_ALL_DONE, 6'd0, 16'd0, 32'd0}}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [MODE_W-1:0]    in_mode_i = '0;
  logic [BURST_W-1:0]   in_burst_time_i = '0;
  logic [RAM_W-1:0]     in_task_ram_i = '0;
  logic [CPU_W-1:0]     in_task_cpu_i = '0;
  logic [PRIO_W-1:0]    in_task_priority_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [STATUS_W-1:0]  out_status_o;
  logic [TIDX_W-1:0]    out_task_index_o;
  logic [BURST_W-1:0]   out_run_length_o;
  logic [ELAPSED_W-1:0] out_elapsed_time_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  round_robin_slice_scheduler_top dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_mode_i,
    .in_burst_time_i,
    .in_task_ram_i,
    .in_task_cpu_i,
    .in_task_priority_i,
    .out_valid_o,
    .out_ready_i,
    .out_status_o,
    .out_task_index_o,
    .out_run_length_o,
    .out_elapsed_time_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Task table and registers as the scheduler should hold them
  logic [BURST_W-1:0]   sched_rem [MAX_TASKS_DEF];
  logic [RAM_W-1:0]     sched_ram [MAX_TASKS_DEF];
  logic [CPU_W-1:0]     sched_cpu [MAX_TASKS_DEF];
  logic                 sched_top [MAX_TASKS_DEF];
  int                   sched_count = 0;
  int                   sched_next = 0;
  logic [ELAPSED_W-1:0] sched_elapsed = '0;
  logic [BURST_W-1:0]   quantum_q = QUANTUM_RST;
  logic [RAM_W-1:0]     pool_top_q = POOL_TOP_RST;
  logic [RAM_W-1:0]     pool_oth_q = POOL_OTH_RST;
  logic [CPU_W-1:0]     cpu_cap_q = CPU_CAP_RST;

  report_t pending_reports [$];
  int      bad_reports = 0;
  int      requests_sent = 0;
  bit      tx_quiet = 1'b0;
  bit      rx_quiet = 1'b0;
  int      rx_stall = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Apply one request to the table; return 1 when it yields a report
  function automatic bit predict_report(input req_t r, output report_t rep);
    int          start;
    int          slot;
    int          k;
    bit          found;
    bit          has;
    logic [BURST_W-1:0] q;
    logic [BURST_W-1:0] run;
    logic [RAM_W-1:0]   pool;
    rep = NO_REP;
    has = 1'b1;
    case (r.mode)
      MODE_LOAD: begin
        if (sched_count >= MAX_TASKS_DEF) begin
          rep.status = ST_FULL;
        end else begin
          sched_rem[sched_count] = r.burst;
          sched_ram[sched_count] = r.ram;
          sched_cpu[sched_count] = r.cpu;
          sched_top[sched_count] = (r.prio == '0);
          rep.status = ST_LOADED;
          rep.idx = TIDX_W'(sched_count);
          sched_count++;
        end
      end
      MODE_STEP: begin
        found = 1'b0;
        slot = 0;
        if (sched_count > 0) begin
          start = (sched_next < sched_count) ? sched_next : 0;
          for (k = 0; k < sched_count && !found; k++) begin
            slot = (start + k) % sched_count;
            if (sched_rem[slot] != '0) found = 1'b1;
          end
        end
        if (!found) begin
          rep.status = ST_ALL_DONE;
        end else begin
          sched_next = slot + 1;
          pool = sched_top[slot] ? pool_top_q : pool_oth_q;
          rep.idx = TIDX_W'(slot);
          if (sched_ram[slot] > pool || sched_cpu[slot] > cpu_cap_q) begin
            // drop the task for good
            sched_rem[slot] = '0;
            rep.status = ST_REJECTED;
          end else begin
            q = (quantum_q == '0) ? BURST_W'(1) : quantum_q;
            run = (sched_rem[slot] < q) ? sched_rem[slot] : q;
            sched_rem[slot] = sched_rem[slot] - run;
            sched_elapsed = sched_elapsed + ELAPSED_W'(run);
            rep.status = (sched_rem[slot] == '0) ? ST_COMPLETED : ST_REQUEUED;
            rep.run = run;
          end
        end
      end
      MODE_CLEAR: begin
        sched_count = 0;
        sched_next = 0;
        sched_elapsed = '0;
        rep.status = ST_CLEARED;
      end
      default: has = 1'b0;
    endcase
    rep.elapsed = sched_elapsed;
    return has;
  endfunction

  function automatic req_t random_request(input logic [MODE_W-1:0] mode);
    req_t r;
    int   pick;
    r.mode = mode;
    pick = $urandom_range(0, 9);
    if (pick == 0) r.burst = '0;
    else if (pick == 1) r.burst = BURST_W'($urandom());
    else r.burst = BURST_W'($urandom_range(1, 50));
    r.ram = ($urandom_range(0, 9) < 7) ? RAM_W'($urandom_range(0, 600)) : RAM_W'($urandom());
    r.cpu = ($urandom_range(0, 9) < 7) ? CPU_W'($urandom_range(0, 110)) : CPU_W'($urandom());
    r.prio = PRIO_W'($urandom());
    return r;
  endfunction

  task automatic push_request(input req_t r, input logic fixed, input report_t fixed_rep);
    report_t rep;
    int      gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_mode_i <= r.mode;
    in_burst_time_i <= r.burst;
    in_task_ram_i <= r.ram;
    in_task_cpu_i <= r.cpu;
    in_task_priority_i <= r.prio;
    do @(posedge clk_i); while (!in_ready_o);
    if (predict_report(r, rep)) begin
      pending_reports.push_back(fixed ? fixed_rep : rep);
      requests_sent++;
    end
  endtask

  // Hold off until every report is back and the block has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_registers(input logic [BURST_W-1:0] q, input logic [RAM_W-1:0] top,
                                 input logic [RAM_W-1:0] oth, input logic [CPU_W-1:0] cap);
    cfg_idx_e idx;
    idx = CFG_QUANTUM;
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      case (idx)
        CFG_QUANTUM:  cfg_data_i <= q;
        CFG_POOL_TOP: cfg_data_i <= CFG_DAT_W'(top);
        CFG_POOL_OTH: cfg_data_i <= CFG_DAT_W'(oth);
        default:      cfg_data_i <= CFG_DAT_W'(cap);
      endcase
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx)
        CFG_QUANTUM:  quantum_q = q;
        CFG_POOL_TOP: pool_top_q = top;
        CFG_POOL_OTH: pool_oth_q = oth;
        default:      cpu_cap_q = cap;
      endcase
      idx = idx.next();
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Report checker and output stall generator
  always @(posedge clk_i) begin : rx_side
    report_t got;
    report_t want;
    int      g;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status_e'(out_status_o), out_task_index_o, out_run_length_o, out_elapsed_time_o};
      if (pending_reports.size() == 0) begin
        bad_reports++;
        if (bad_reports <= 10)
          $display("unexpected report: status %0d index %0d run %0d elapsed %0d",
                   got.status, got.idx, got.run, got.elapsed);
      end else begin
        want = pending_reports.pop_front();
        if (got.status != want.status || got.idx != want.idx || got.run != want.run ||
            got.elapsed != want.elapsed) begin
          bad_reports++;
          if (bad_reports <= 10)
            $display("report mismatch: expected status %0d index %0d run %0d elapsed %0d, %s",
                     want.status, want.idx, want.run, want.elapsed,
                     $sformatf("got status %0d index %0d run %0d elapsed %0d",
                               got.status, got.idx, got.run, got.elapsed));
        end
      end
    end
    if (rx_stall > 0) begin
      rx_stall--;
      out_ready_i <= 1'b0;
    end else begin
      g = rx_quiet ? 0 : pick_gap();
      if (g > 0) begin
        rx_stall = g - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    #(8 * 2_000_000);
    $display("round_robin_slice_scheduler_top test failed");
    $finish;
  end

  initial begin
    int          phase;
    int          nload;
    int          nstep;
    int          pick;
    logic [BURST_W-1:0] q;
    logic [RAM_W-1:0]   top;
    logic [RAM_W-1:0]   oth;
    logic [CPU_W-1:0]   cap;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++)
      push_request(DIR_TAB[i].req, DIR_TAB[i].fixed, DIR_TAB[i].rep);

    phase = 0;
    while (requests_sent < TARGET_REQUESTS) begin
      drain();
      case (phase)
        0: begin q = '0;       top = 12'hfff; oth = 12'hfff; cap = 8'hff; end
        1: begin q = 16'd1;    top = '0;      oth = '0;      cap = '0;    end
        2: begin q = 16'hffff; top = 12'd512; oth = 12'd1536; cap = 8'd100; end
        default: begin
          pick = $urandom_range(0, 9);
          q = (pick == 0) ? '0 : (pick == 1) ? BURST_W'($urandom()) :
              BURST_W'($urandom_range(1, 16));
          pick = $urandom_range(0, 9);
          top = (pick == 0) ? '0 : (pick == 1) ? 12'hfff : RAM_W'($urandom_range(300, 4095));
          pick = $urandom_range(0, 9);
          oth = (pick == 0) ? '0 : (pick == 1) ? 12'hfff : RAM_W'($urandom_range(300, 4095));
          pick = $urandom_range(0, 9);
          cap = (pick == 0) ? '0 : (pick == 1) ? 8'hff : CPU_W'($urandom_range(60, 255));
        end
      endcase
      write_registers(q, top, oth, cap);
      tx_quiet = ($urandom_range(0, 6) == 0);
      rx_quiet = ($urandom_range(0, 6) == 0);

      if ($urandom_range(0, 3) != 0) push_request(random_request(MODE_CLEAR), 1'b0, NO_REP);
      // now and then fill the table past its capacity
      nload = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
      repeat (nload) push_request(random_request(MODE_LOAD), 1'b0, NO_REP);
      nstep = $urandom_range(5, 60);
      repeat (nstep) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) push_request(random_request(MODE_STEP), 1'b0, NO_REP);
        else if (pick < 92) push_request(random_request(MODE_LOAD), 1'b0, NO_REP);
        else if (pick < 95) push_request(random_request(MODE_CLEAR), 1'b0, NO_REP);
        else if (pick < 98) push_request(random_request(MODE_UNUSED), 1'b0, NO_REP);
        else drain();
      end
      phase++;
    end

    drain();
    if (bad_reports == 0 && pending_reports.size() == 0) begin
      $display("round_robin_slice_scheduler_top test passed");
    end else begin
      $display("round_robin_slice_scheduler_top test failed");
    end
    $finish;
  end

endmodule
